FILE: hdl/pvcr_pkg.sv
// ----------------------------------------------------------------------------
// pvcr_pkg
// Shared widths, codes, control structs and small constant tables for the
// packed voxel channel reader.
// ----------------------------------------------------------------------------
package pvcr_pkg;

    localparam int PVCR_FRAME_BYTES = 4096;

    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int FUNC_W      = 3;
    localparam int BADDR_W     = 12;
    localparam int BYTE_W      = 8;
    localparam int CHAN_W      = 4;
    localparam int COORD_W     = 3;
    localparam int VALUE_W     = 8;
    localparam int STATUS_W    = 2;

    // voxel index of a 15-wide cube at coordinate 7: below 2^11
    localparam int VOX_W       = 11;
    // voxel * (count*size) + channel*size with an 8-bit stride
    localparam int POS_W       = 19;
    localparam int BIDX_W      = POS_W - 3;
    localparam int PROD_IN_W   = 2 * BYTE_W;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CUBE_SIDE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SIZE  = 2'd2;

    localparam logic [CFG_W-1:0] SIDE_RST  = 4'd8;
    localparam logic [CFG_W-1:0] COUNT_RST = 4'd1;
    localparam logic [CFG_W-1:0] SIZE_RST  = 4'd1;

    localparam logic [FUNC_W-1:0] FN_LOAD       = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CHAN_LEVEL = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CHAN_BIT   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_VOX_LEVEL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_VOX_BIT    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    typedef struct packed {
        logic capture;
        logic check;
        logic pos;
        logic rd0;
        logic rd1;
        logic rd2;
        logic sc1;
        logic sc2;
        logic out_load;
    } pvcr_cmd_t;

    typedef struct packed {
        logic done_early;
        logic bad0;
        logic is_bit;
        logic straddle;
        logic bad1;
    } pvcr_sts_t;

    function automatic logic [BYTE_W-1:0] field_mask(input logic [CFG_W-1:0] size);
        logic [BYTE_W:0] m;
        m = ({{BYTE_W{1'b0}}, 1'b1} << size) - {{BYTE_W{1'b0}}, 1'b1};
        return m[BYTE_W-1:0];
    endfunction

    // floor(2^24 / (2^size - 1))
    function automatic logic [RECIP_W-1:0] recip(input logic [CFG_W-1:0] size);
        logic [RECIP_W-1:0] r;
        case (size)
            4'd1:    r = 25'd16777216;
            4'd2:    r = 25'd5592405;
            4'd3:    r = 25'd2396745;
            4'd4:    r = 25'd1118481;
            4'd5:    r = 25'd541200;
            4'd6:    r = 25'd266305;
            4'd7:    r = 25'd132104;
            4'd8:    r = 25'd65793;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/pvcr_req_if.sv
// ----------------------------------------------------------------------------
// pvcr_req_if
// Request channel: valid/ready with one frame load or voxel read.
// ----------------------------------------------------------------------------
interface pvcr_req_if
    import pvcr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [BADDR_W-1:0]   byte_address;
    logic [BYTE_W-1:0]    byte_data;
    logic [CHAN_W-1:0]    channel;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   z;

    modport source (
        output valid, func, byte_address, byte_data, channel, x, y, z,
        input  ready
    );

    modport sink (
        input  valid, func, byte_address, byte_data, channel, x, y, z,
        output ready
    );
endinterface

FILE: hdl/pvcr_rsp_if.sv
// ----------------------------------------------------------------------------
// pvcr_rsp_if
// Response channel: valid/ready with one value and status.
// ----------------------------------------------------------------------------
interface pvcr_rsp_if
    import pvcr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   value;
    logic [STATUS_W-1:0]  status;

    modport source (
        output valid, value, status,
        input  ready
    );

    modport sink (
        input  valid, value, status,
        output ready
    );
endinterface

FILE: hdl/pvcr_datapath.sv
// ----------------------------------------------------------------------------
// pvcr_datapath
// Configuration registers, frame memory, address arithmetic, field extract
// and scaling, and the output register.
// ----------------------------------------------------------------------------
module pvcr_datapath
    import pvcr_pkg::*;
#(
    parameter int FRAME_BYTES = PVCR_FRAME_BYTES
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [FUNC_W-1:0]     func,
    input  logic [BADDR_W-1:0]    byte_address,
    input  logic [BYTE_W-1:0]     byte_data,
    input  logic [CHAN_W-1:0]     channel,
    input  logic [COORD_W-1:0]    x,
    input  logic [COORD_W-1:0]    y,
    input  logic [COORD_W-1:0]    z,
    input  pvcr_cmd_t             cmd,
    output pvcr_sts_t             sts,
    output logic [VALUE_W-1:0]    value,
    output logic [STATUS_W-1:0]   status
);

    localparam int AW      = $clog2(FRAME_BYTES);
    localparam int LIM_W   = $clog2(FRAME_BYTES + 1);
    localparam int CMP_W   = (LIM_W > BIDX_W + 1) ? LIM_W : BIDX_W + 1;
    localparam int PROD_W  = PROD_IN_W + RECIP_W;
    localparam logic [CMP_W-1:0] FB_LIM = CMP_W'(FRAME_BYTES);

    // configuration
    logic [CFG_W-1:0]     side_reg, count_reg, size_reg;
    logic [2*CFG_W-1:0]   side_sq_reg, stride_reg;

    // captured request
    logic [FUNC_W-1:0]    func_reg;
    logic [BADDR_W-1:0]   baddr_reg;
    logic [BYTE_W-1:0]    bdata_reg;
    logic [CHAN_W-1:0]    chan_reg;
    logic [COORD_W-1:0]   x_reg, y_reg, z_reg;

    // work registers
    logic [VOX_W-1:0]     voxel_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [BYTE_W-1:0]    byte0_reg;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic [PROD_IN_W-1:0] p_reg;
    logic [VALUE_W-1:0]   q0_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    logic [BYTE_W-1:0]    mem [FRAME_BYTES];

    logic                 is_level, is_voxel;
    logic [CHAN_W-1:0]    chan_eff;
    logic [STATUS_W-1:0]  chk_status;
    logic [VOX_W-1:0]     vox_calc;
    logic [2*CFG_W-1:0]   mul_b, add_t;
    logic [POS_W-1:0]     pos_calc;
    logic [BIDX_W-1:0]    byte_idx;
    logic [2:0]           off;
    logic [CMP_W-1:0]     idx0_ext, idx1_ext, load_ext;
    logic                 load_ok, mem_we;
    logic [AW-1:0]        rd_addr;
    logic [BYTE_W-1:0]    mask;
    logic [PROD_IN_W-1:0] word, p_calc;
    logic [BYTE_W-1:0]    field;
    logic [PROD_W-1:0]    prod;
    logic [PROD_IN_W-1:0] qd, rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= SIDE_RST;
            count_reg   <= COUNT_RST;
            size_reg    <= SIZE_RST;
            side_sq_reg <= 8'(SIDE_RST * SIDE_RST);
            stride_reg  <= 8'(COUNT_RST * SIZE_RST);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_CUBE_SIDE:
                begin
                    side_reg    <= cfg_wdata;
                    side_sq_reg <= {4'b0, cfg_wdata} * {4'b0, cfg_wdata};
                end
                CFG_CHANNEL_COUNT:
                begin
                    count_reg  <= cfg_wdata;
                    stride_reg <= {4'b0, cfg_wdata} * {4'b0, size_reg};
                end
                CFG_CHANNEL_SIZE:
                begin
                    size_reg   <= cfg_wdata;
                    stride_reg <= {4'b0, count_reg} * {4'b0, cfg_wdata};
                end
                default:
                begin
                    side_reg <= side_reg;
                end
            endcase
        end
    end

    assign is_level = func_reg inside {FN_CHAN_LEVEL, FN_VOX_LEVEL};
    assign is_voxel = func_reg inside {FN_VOX_LEVEL, FN_VOX_BIT};
    assign chan_eff = is_voxel ? '0 : chan_reg;

    // mode checks first, then the cube bounds
    always_comb
    begin
        chk_status = ST_OK;
        if (func_reg == FN_LOAD)
            chk_status = ST_OK;
        else if (func_reg > FN_VOX_BIT)
            chk_status = ST_REJECT;
        else if (is_voxel && count_reg != 4'd1)
            chk_status = ST_REJECT;
        else if (chan_eff >= count_reg)
            chk_status = ST_REJECT;
        else if (is_level && (size_reg == 4'd0 || size_reg > 4'd8))
            chk_status = ST_REJECT;
        else if (!is_level && size_reg != 4'd1)
            chk_status = ST_REJECT;
        else if ({1'b0, x_reg} >= side_reg || {1'b0, y_reg} >= side_reg ||
                 {1'b0, z_reg} >= side_reg)
            chk_status = ST_OUTSIDE;
    end

    assign vox_calc = VOX_W'(side_sq_reg) * VOX_W'(z_reg) +
                      VOX_W'(side_reg) * VOX_W'(y_reg) + VOX_W'(x_reg);

    assign mul_b    = is_level ? stride_reg : {4'b0, count_reg};
    assign add_t    = is_level ? {4'b0, chan_eff} * {4'b0, size_reg} : {4'b0, chan_eff};
    assign pos_calc = POS_W'(voxel_reg) * POS_W'(mul_b) + POS_W'(add_t);

    assign byte_idx = pos_reg[POS_W-1:3];
    assign off      = pos_reg[2:0];
    assign idx0_ext = CMP_W'(byte_idx);
    assign idx1_ext = idx0_ext + CMP_W'(1);
    assign load_ext = CMP_W'(baddr_reg);
    assign load_ok  = load_ext < FB_LIM;
    assign mem_we   = cmd.check && (func_reg == FN_LOAD) && load_ok;
    assign rd_addr  = cmd.rd1 ? idx1_ext[AW-1:0] : idx0_ext[AW-1:0];

    assign mask   = field_mask(size_reg);
    assign word   = cmd.rd2 ? {rd_data_reg, byte0_reg} : {{BYTE_W{1'b0}}, rd_data_reg};
    assign field  = BYTE_W'(word >> off) & mask;
    // field * 255
    assign p_calc = {field, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, field};

    assign prod = PROD_W'(p_reg) * PROD_W'(recip(size_reg));
    // q0 * (2^size - 1)
    assign qd   = (PROD_IN_W'(q0_reg) << size_reg) - PROD_IN_W'(q0_reg);
    assign rem  = p_reg - qd;

    assign sts.done_early = (func_reg == FN_LOAD) || (chk_status != ST_OK);
    assign sts.bad0       = idx0_ext >= FB_LIM;
    assign sts.is_bit     = !is_level;
    assign sts.straddle   = ({2'b0, off} + {1'b0, size_reg}) > 5'd8;
    assign sts.bad1       = idx1_ext >= FB_LIM;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[load_ext[AW-1:0]] <= bdata_reg;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            baddr_reg <= byte_address;
            bdata_reg <= byte_data;
            chan_reg  <= channel;
            x_reg     <= x;
            y_reg     <= y;
            z_reg     <= z;
        end
        if (cmd.check)
        begin
            status_reg <= chk_status;
            value_reg  <= '0;
            voxel_reg  <= vox_calc;
        end
        if (cmd.pos)
            pos_reg <= pos_calc;
        if (cmd.rd0 && sts.bad0)
            status_reg <= ST_REJECT;
        if (cmd.rd1)
        begin
            byte0_reg <= rd_data_reg;
            p_reg     <= p_calc;
            if (sts.is_bit)
                value_reg <= VALUE_W'(rd_data_reg[off]);
            else if (sts.straddle && sts.bad1)
                status_reg <= ST_REJECT;
        end
        if (cmd.rd2)
            p_reg <= p_calc;
        if (cmd.sc1)
            q0_reg <= prod[RECIP_SHIFT +: VALUE_W];
        if (cmd.sc2)
            value_reg <= (rem >= PROD_IN_W'(mask)) ? q0_reg + VALUE_W'(1) : q0_reg;
        if (cmd.out_load)
        begin
            out_value_reg  <= value_reg;
            out_status_reg <= status_reg;
        end
    end

    assign value  = out_value_reg;
    assign status = out_status_reg;

    // the reciprocal estimate is never more than one short
    a_scale_one_fix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sc2 |-> (rem < PROD_IN_W'({mask, 1'b0})))
        else $error("scale remainder out of range");

    // the second byte is fetched only for a field that crosses a byte edge
    a_rd2_straddle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd2 |-> (sts.straddle && !sts.is_bit && !sts.bad1))
        else $error("second byte read without straddle");

endmodule

FILE: hdl/pvcr_ctrl.sv
// ----------------------------------------------------------------------------
// pvcr_ctrl
// Sequencer for one request at a time: check, position, byte reads,
// scaling, then hand-off into the output register.
// ----------------------------------------------------------------------------
module pvcr_ctrl
    import pvcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  pvcr_sts_t  sts,
    output pvcr_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_RD0   = 4'd3;
    localparam logic [3:0] S_RD1   = 4'd4;
    localparam logic [3:0] S_RD2   = 4'd5;
    localparam logic [3:0] S_SC1   = 4'd6;
    localparam logic [3:0] S_SC2   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free, in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        cmd.capture  = in_fire;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.done_early ? S_DONE : S_POS;
            end
            S_POS:
            begin
                cmd.pos    = 1'b1;
                state_next = S_RD0;
            end
            S_RD0:
            begin
                cmd.rd0    = 1'b1;
                state_next = sts.bad0 ? S_DONE : S_RD1;
            end
            S_RD1:
            begin
                cmd.rd1 = 1'b1;
                if (sts.is_bit)
                    state_next = S_DONE;
                else if (!sts.straddle)
                    state_next = S_SC1;
                else if (sts.bad1)
                    state_next = S_DONE;
                else
                    state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = S_SC1;
            end
            S_SC1:
            begin
                cmd.sc1    = 1'b1;
                state_next = S_SC2;
            end
            S_SC2:
            begin
                cmd.sc2    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transfer");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_CHECK && !in_ready))
        else $error("accepted request did not start");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result not presented after load");

endmodule

FILE: hdl/packed_voxel_channel_reader.sv
// ----------------------------------------------------------------------------
// packed_voxel_channel_reader
// Packed LED-cube frame store with byte loads and scaled channel reads.
// ----------------------------------------------------------------------------
// Takes one request at a time and answers each with one response. A load, a
// mode reject or an out-of-cube read goes from the check straight to the
// output register. A read whose first byte lies past the end of the frame
// stops at the first byte read, and one whose crossing field has its second
// byte past it stops at the second. A one-bit state read ends after one byte
// read; a level read also scales, and a level read whose field crosses a byte
// edge reads a second byte first. The sequencer walks check, position multiply,
// one registered frame-memory read per byte, and a two-step reciprocal scale
// by 2^size-1. The next request can transfer on the cycle after the result
// enters the output register. A finished result waits in its own output
// register, so the next request is taken while it is still pending. The frame
// memory holds FRAME_BYTES bytes with separate write and read ports; a byte
// read before it was ever loaded returns an arbitrary value. Configuration
// writes belong to idle periods only; the block itself does not enforce it.
module packed_voxel_channel_reader
    import pvcr_pkg::*;
#(
    parameter int FRAME_BYTES = PVCR_FRAME_BYTES
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    pvcr_req_if.sink              req,
    pvcr_rsp_if.source            rsp
);

    pvcr_cmd_t cmd;
    pvcr_sts_t sts;

    pvcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pvcr_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .func         (req.func),
        .byte_address (req.byte_address),
        .byte_data    (req.byte_data),
        .channel      (req.channel),
        .x            (req.x),
        .y            (req.y),
        .z            (req.z),
        .cmd          (cmd),
        .sts          (sts),
        .value        (rsp.value),
        .status       (rsp.status)
    );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the packed voxel channel reader. A queue of requests feeds a
// bursty valid/ready driver; a scoreboard predicts every response from its own
// copy of the frame and geometry, and a monitor checks value and status in
// order while the receiver stalls on a changing pattern. The run steps through
// several cube geometries, including degenerate and oversized ones.
// ----------------------------------------------------------------------------
module tb
    import pvcr_pkg::*;
;

    localparam int CLK_HALF_NS   = 4;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT  = 10;
    localparam int LONG_HOLD     = 400;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_pattern_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0]  byte_data;
        logic [CHAN_W-1:0]  channel;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } voxel_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } voxel_rsp_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        bit                  touches;
        bit                  level;
        bit                  two;
        int unsigned         idx;
        int unsigned         off;
    } field_loc_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    pvcr_req_if req_ch ();
    pvcr_rsp_if rsp_ch ();

    packed_voxel_channel_reader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    voxel_req_t  pending_requests[$];
    voxel_rsp_t  expected_responses[$];
    logic [7:0]  frame_image [PVCR_FRAME_BYTES];
    bit          byte_loaded [PVCR_FRAME_BYTES];
    int unsigned geom_side;
    int unsigned geom_count;
    int unsigned geom_size;
    int          mismatches = 0;
    bit          long_hold_request = 1'b0;

    // Work out where a read lands under the current geometry, or why it fails.
    function automatic field_loc_t locate_field(input voxel_req_t it);
        field_loc_t  p;
        int unsigned chan;
        int unsigned voxel;
        int unsigned pos;
        p.status  = ST_OK;
        p.touches = 1'b0;
        p.level   = 1'b0;
        p.two     = 1'b0;
        p.idx     = 0;
        p.off     = 0;
        chan      = it.channel;
        if (it.func == FN_LOAD)
            return p;
        if (it.func > FN_VOX_BIT)
        begin
            p.status = ST_REJECT;
            return p;
        end
        p.level = (it.func == FN_CHAN_LEVEL) || (it.func == FN_VOX_LEVEL);
        if (it.func == FN_VOX_LEVEL || it.func == FN_VOX_BIT)
        begin
            if (geom_count != 1)
            begin
                p.status = ST_REJECT;
                return p;
            end
            chan = 0;
        end
        if (chan >= geom_count)
        begin
            p.status = ST_REJECT;
            return p;
        end
        if (p.level ? (geom_size == 0 || geom_size > BYTE_W) : (geom_size != 1))
        begin
            p.status = ST_REJECT;
            return p;
        end
        if (it.x >= geom_side || it.y >= geom_side || it.z >= geom_side)
        begin
            p.status = ST_OUTSIDE;
            return p;
        end
        voxel = geom_side * geom_side * it.z + geom_side * it.y + it.x;
        if (p.level)
            pos = voxel * geom_count * geom_size + chan * geom_size;
        else
            pos = voxel * geom_count + chan;
        p.idx = pos >> 3;
        p.off = pos & 7;
        if (p.idx >= PVCR_FRAME_BYTES)
        begin
            p.status = ST_REJECT;
            return p;
        end
        if (p.level && p.off + geom_size > BYTE_W)
        begin
            if (p.idx + 1 >= PVCR_FRAME_BYTES)
            begin
                p.status = ST_REJECT;
                return p;
            end
            p.two = 1'b1;
        end
        p.touches = 1'b1;
        return p;
    endfunction

    function automatic void predict_response(input voxel_req_t it);
        field_loc_t  p;
        voxel_rsp_t  r;
        int unsigned word;
        int unsigned maxv;
        p        = locate_field(it);
        r.status = p.status;
        r.value  = '0;
        if (it.func == FN_LOAD)
            frame_image[it.byte_address] = it.byte_data;
        else if (p.touches)
        begin
            word = int'(frame_image[p.idx]);
            if (p.two)
                word = word | (int'(frame_image[p.idx + 1]) << 8);
            if (!p.level)
                r.value = VALUE_W'((word >> p.off) & 1);
            else
            begin
                maxv    = (1 << geom_size) - 1;
                r.value = VALUE_W'((((word >> p.off) & maxv) * 255) / maxv);
            end
        end
        expected_responses.push_back(r);
    endfunction

    function automatic voxel_req_t random_fields();
        voxel_req_t it;
        it.func         = FN_LOAD;
        it.byte_address = BADDR_W'($urandom);
        it.byte_data    = BYTE_W'($urandom);
        it.channel      = CHAN_W'($urandom);
        it.x            = COORD_W'($urandom);
        it.y            = COORD_W'($urandom);
        it.z            = COORD_W'($urandom);
        return it;
    endfunction

    // Load any byte the read needs that has never been written, then queue it.
    task automatic push_request(input voxel_req_t it);
        field_loc_t  p;
        voxel_req_t  fill;
        int unsigned k;
        p = locate_field(it);
        if (p.touches)
        begin
            for (k = 0; k < 2; k++)
            begin
                if ((k == 0 || p.two) && !byte_loaded[p.idx + k])
                begin
                    fill              = random_fields();
                    fill.byte_address = BADDR_W'(p.idx + k);
                    byte_loaded[p.idx + k] = 1'b1;
                    pending_requests.push_back(fill);
                end
            end
        end
        if (it.func == FN_LOAD)
            byte_loaded[it.byte_address] = 1'b1;
        pending_requests.push_back(it);
    endtask

    task automatic push_op(input logic [FUNC_W-1:0] func, input int unsigned addr,
                           input int unsigned data, input int unsigned chan,
                           input int unsigned x, input int unsigned y,
                           input int unsigned z);
        voxel_req_t it;
        it.func         = func;
        it.byte_address = BADDR_W'(addr);
        it.byte_data    = BYTE_W'(data);
        it.channel      = CHAN_W'(chan);
        it.x            = COORD_W'(x);
        it.y            = COORD_W'(y);
        it.z            = COORD_W'(z);
        push_request(it);
    endtask

    task automatic push_random(input int unsigned n_items);
        voxel_req_t        it;
        logic [FUNC_W-1:0] legal[$];
        int unsigned       region;
        int unsigned       span;
        int unsigned       pick;
        legal = {};
        if (geom_size >= 1 && geom_size <= BYTE_W)
            legal.push_back(FN_CHAN_LEVEL);
        if (geom_size == 1)
            legal.push_back(FN_CHAN_BIT);
        if (geom_count == 1 && geom_size >= 1 && geom_size <= BYTE_W)
            legal.push_back(FN_VOX_LEVEL);
        if (geom_count == 1 && geom_size == 1)
            legal.push_back(FN_VOX_BIT);
        if (legal.size() == 0)
            legal.push_back(FN_CHAN_LEVEL);
        region = (geom_side * geom_side * geom_side * geom_count * geom_size + 7) / 8;
        if (region > PVCR_FRAME_BYTES)
            region = PVCR_FRAME_BYTES;
        span = (geom_side > 8) ? 8 : geom_side;
        repeat (n_items)
        begin
            it   = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // keep most loads inside the part of the frame the cube uses
                if (region > 0 && $urandom_range(0, 3) != 0)
                    it.byte_address = BADDR_W'($urandom_range(0, region - 1));
            end
            else if (pick < 85)
            begin
                it.func = legal[$urandom_range(0, legal.size() - 1)];
                if (geom_count > 0)
                    it.channel = CHAN_W'($urandom_range(0, geom_count - 1));
                if (span > 0)
                begin
                    it.x = COORD_W'($urandom_range(0, span - 1));
                    it.y = COORD_W'($urandom_range(0, span - 1));
                    it.z = COORD_W'($urandom_range(0, span - 1));
                end
            end
            else
                it.func = FUNC_W'($urandom_range(FN_CHAN_LEVEL, FN_SPARE_HI));
            push_request(it);
        end
    endtask

    task automatic drain_responses();
        @(negedge clk);
        while (pending_requests.size() != 0 || expected_responses.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_geometry(input int unsigned side, input int unsigned count,
                                input int unsigned size);
        drain_responses();
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_CUBE_SIDE;
        cfg_wdata <= CFG_W'(side);
        @(posedge clk);
        cfg_index <= CFG_CHANNEL_COUNT;
        cfg_wdata <= CFG_W'(count);
        @(posedge clk);
        cfg_index <= CFG_CHANNEL_SIZE;
        cfg_wdata <= CFG_W'(size);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        geom_side  = side;
        geom_count = count;
        geom_size  = size;
        @(negedge clk);
    endtask

    // Request driver: bursts of transfers separated by random gaps.
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin : driver
        bit took;
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.func         <= FN_LOAD;
            req_ch.byte_address <= '0;
            req_ch.byte_data    <= '0;
            req_ch.channel      <= '0;
            req_ch.x            <= '0;
            req_ch.y            <= '0;
            req_ch.z            <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            took = req_ch.valid && req_ch.ready;
            if (took)
            begin
                predict_response(pending_requests.pop_front());
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                             : $urandom_range(0, 5);
                end
            end
            if (req_ch.valid && !took)
                ; // hold the offered item until it transfers
            else if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                req_ch.valid        <= 1'b1;
                req_ch.func         <= pending_requests[0].func;
                req_ch.byte_address <= pending_requests[0].byte_address;
                req_ch.byte_data    <= pending_requests[0].byte_data;
                req_ch.channel      <= pending_requests[0].channel;
                req_ch.x            <= pending_requests[0].x;
                req_ch.y            <= pending_requests[0].y;
                req_ch.z            <= pending_requests[0].z;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response receiver: a pattern that changes at random intervals, plus
    // one long hold-off on request.
    rx_pattern_t rx_mode;
    int unsigned rx_seg;
    int unsigned hold_left;
    bit          hold_taken;

    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_mode    = RX_OPEN;
            rx_seg     = 0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end
        else
        begin
            if (long_hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (rx_seg == 0)
            begin
                rx_mode = rx_pattern_t'($urandom_range(0, 3));
                rx_seg  = $urandom_range(10, 80);
            end
            else
                rx_seg--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:   rsp_ch.ready <= 1'b1;
                    RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ch.ready <= ((rx_seg % 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        voxel_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: response with none expected: value %0d status %0d",
                             $time, rsp_ch.value, rsp_ch.status);
            end
            else
            begin
                want = expected_responses.pop_front();
                if (rsp_ch.value !== want.value || rsp_ch.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: mismatch: value exp %0d got %0d, status exp %0d got %0d",
                                 $time, want.value, rsp_ch.value, want.status, rsp_ch.status);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = CFG_CUBE_SIDE;
        cfg_wdata    = '0;
        geom_side    = SIDE_RST;
        geom_count   = COUNT_RST;
        geom_size    = SIZE_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: 8-wide cube, one single-bit channel
        push_op(FN_LOAD, 0, 8'hFF, 0, 0, 0, 0);
        push_op(FN_LOAD, PVCR_FRAME_BYTES - 1, 8'h00, 0, 0, 0, 0);
        push_op(FN_LOAD, PVCR_FRAME_BYTES - 1, 8'h80, 0, 0, 0, 0);
        push_op(FN_CHAN_BIT, 0, 0, 0, 0, 0, 0);
        push_op(FN_VOX_BIT, 0, 0, 0, 7, 7, 7);
        push_op(FN_VOX_LEVEL, 0, 0, 0, 0, 0, 0);
        push_op(FN_CHAN_LEVEL, 0, 0, 1, 0, 0, 0);
        push_op(FN_SPARE_LO, 0, 0, 0, 0, 0, 0);
        push_op(FN_SPARE_HI, 0, 0, 0, 0, 0, 0);
        push_random(150);

        // three 3-bit channels: fields cross byte edges
        set_geometry(3, 3, 3);
        push_op(FN_CHAN_LEVEL, 0, 0, 2, 0, 0, 0);
        push_op(FN_VOX_LEVEL, 0, 0, 0, 1, 1, 1);
        push_op(FN_CHAN_BIT, 0, 0, 0, 1, 1, 1);
        push_op(FN_CHAN_LEVEL, 0, 0, 0, 3, 0, 0);
        push_op(FN_CHAN_LEVEL, 0, 0, 3, 0, 0, 0);
        push_op(FN_CHAN_LEVEL, 0, 0, 15, 0, 0, 0);
        push_random(150);

        // full frame; the receiver holds off while requests keep coming
        set_geometry(8, 8, 8);
        push_op(FN_LOAD, PVCR_FRAME_BYTES - 1, 8'hFF, 0, 0, 0, 0);
        push_op(FN_CHAN_LEVEL, 0, 0, 7, 7, 7, 7);
        push_op(FN_LOAD, 1, 8'h00, 0, 0, 0, 0);
        push_op(FN_CHAN_LEVEL, 0, 0, 1, 0, 0, 0);
        push_random(130);
        long_hold_request = 1'b1;

        // oversized cube: far voxels fall past the end of the frame
        set_geometry(15, 8, 8);
        push_op(FN_CHAN_LEVEL, 0, 0, 7, 7, 7, 7);
        push_op(FN_CHAN_LEVEL, 0, 0, 0, 0, 0, 0);
        push_random(60);

        set_geometry(0, 0, 0);
        push_op(FN_CHAN_LEVEL, 0, 0, 0, 0, 0, 0);
        set_geometry(0, 1, 1);
        push_op(FN_VOX_BIT, 0, 0, 0, 0, 0, 0);
        set_geometry(5, 1, 0);
        push_op(FN_VOX_LEVEL, 0, 0, 0, 1, 2, 3);
        push_op(FN_VOX_BIT, 0, 0, 0, 1, 2, 3);
        set_geometry(5, 1, 12);
        push_op(FN_CHAN_LEVEL, 0, 0, 0, 1, 2, 3);

        set_geometry(1, 1, 8);
        push_random(80);
        set_geometry(6, 2, 1);
        push_random(150);
        set_geometry(8, 1, 4);
        push_random(75);
        // pause the sender until every response is back
        drain_responses();
        push_random(75);
        set_geometry(2, 5, 7);
        push_random(150);

        drain_responses();
        if (mismatches == 0 && expected_responses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pvcr_pkg.sv
hdl/pvcr_req_if.sv
hdl/pvcr_rsp_if.sv
hdl/pvcr_datapath.sv
hdl/pvcr_ctrl.sv
hdl/packed_voxel_channel_reader.sv
sim/tb.sv
